@@ hw/rtl/ukt_pkg.sv @@
// Package for the unordered key table: request and response structs, the scan
// token and the cell write port, plus the operation and status codes.
// No dependencies; every other file of the block uses it.
package ukt_pkg;

  // Position width for the largest supported table (4096 entries plus one).
  localparam int unsigned PosW = 13;
  localparam int unsigned KeyW = 31;
  localparam int unsigned PayW = 64;
  localparam int unsigned CapW = 7;
  localparam int unsigned ResW = 7;

  localparam logic [1:0] FuncSearch = 2'd0;
  localparam logic [1:0] FuncInsert = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StDup      = 3'd2,
    StEmpty    = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]      func;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic [ResW-1:0] index;
    logic [ResW-1:0] count;
  } res_t;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic            found;
    logic [PosW-1:0] pos;
    logic [KeyW-1:0] last_key;
    logic [PayW-1:0] last_payload;
  } token_t;

  typedef struct packed {
    logic            en;
    logic [PosW-1:0] pos;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] payload;
  } wr_t;

endpackage

@@ hw/rtl/ukt_cell.sv @@
// One cell of the key table chain: holds one entry and forwards the scan token.
// Depends on ukt_pkg for the token and write port types.
module ukt_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ukt_pkg::token_t                tok_i,
  input  ukt_pkg::wr_t                   wr_i,
  input  logic [ukt_pkg::PosW-1:0]       count_i,
  output ukt_pkg::token_t                tok_o
);

  localparam logic [ukt_pkg::PosW-1:0] MyPos = ukt_pkg::PosW'(Idx);

  logic [ukt_pkg::KeyW-1:0] key_q;
  logic [ukt_pkg::PayW-1:0] payload_q;
  logic                     valid_q;
  ukt_pkg::token_t          tok_d;
  ukt_pkg::token_t          tok_q;
  logic                     hit;
  logic                     is_last;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.pos == MyPos)) begin
      key_q     <= wr_i.key;
      payload_q <= wr_i.payload;
    end
  end

  assign hit     = tok_i.valid && !tok_i.found && (MyPos < count_i) && (key_q == tok_i.key);
  assign is_last = (MyPos == (count_i - ukt_pkg::PosW'(1)));

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.pos   = MyPos;
    end
    if (is_last) begin
      tok_d.last_key     = key_q;
      tok_d.last_payload = payload_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

@@ hw/rtl/unordered_key_table_engine.sv @@
// Unordered key table engine: a chain of DEPTH cells, each holding one entry.
// A request's scan token walks the chain one cell per cycle, collecting the
// first match and the last entry in use; the control logic then updates the
// table and reports the result. Depends on ukt_pkg and ukt_cell.
//
// Usage: a request transfer happens at a rising edge with start high and busy
// low; req_i carries the operation, key and payload. The token passes all DEPTH
// cells, one per cycle; after the last cell the result is registered and done_o
// pulses for one cycle, with res_o valid in that cycle. The receiver cannot
// stall; the result transfer happens at the end of that cycle. busy drops in the
// same cycle as done_o, so a new request can be taken from that cycle on. The
// capacity register is written through cfg_we_i and cfg_wdata_i; the user must
// write it only while the block is idle, as the block does not enforce this.
// Reset empties the table and sets the capacity to 64; entry contents are not
// cleared, and the table is ready for a request in the first cycle after reset.
module unordered_key_table_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  ukt_pkg::req_t               req_i,
  output logic                        done_o,
  output ukt_pkg::res_t               res_o,
  input  logic                        cfg_we_i,
  input  logic [ukt_pkg::CapW-1:0]    cfg_wdata_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [ukt_pkg::PosW-1:0] DepthP = ukt_pkg::PosW'(DEPTH);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  state_e                     state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [ukt_pkg::CapW-1:0]   capacity_q;
  ukt_pkg::req_t              req_q;
  logic                       done_q, done_d;
  ukt_pkg::res_t              res_q, res_d;
  ukt_pkg::token_t            tok [DEPTH+1];
  ukt_pkg::wr_t               wr;
  logic                       accept;
  logic                       finish;
  logic [ukt_pkg::PosW-1:0]   count_ext;
  logic [ukt_pkg::PosW-1:0]   cap_ext;
  logic [ukt_pkg::PosW-1:0]   cap_eff;
  logic [ukt_pkg::PosW-1:0]   idx;
  logic [ukt_pkg::PosW-1:0]   new_count_ext;
  ukt_pkg::status_e           status;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign finish = (state_q == StScan) && tok[DEPTH].valid;

  always_comb begin
    tok[0]              = '0;
    tok[0].valid        = accept;
    tok[0].key          = req_i.key;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ukt_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[i]),
      .wr_i   (wr),
      .count_i(count_ext),
      .tok_o  (tok[i+1])
    );
  end

  assign count_ext = ukt_pkg::PosW'(count_q);
  assign cap_ext   = ukt_pkg::PosW'(capacity_q);
  assign cap_eff   = (cap_ext < DepthP) ? cap_ext : DepthP;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    wr      = '0;
    status  = ukt_pkg::StOk;
    idx     = count_ext;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (finish) begin
          state_d = StIdle;
          case (req_q.func)
            ukt_pkg::FuncInsert: begin
              if (count_ext >= cap_eff) begin
                status = ukt_pkg::StFull;
              end else if (tok[DEPTH].found) begin
                status = ukt_pkg::StDup;
                idx    = tok[DEPTH].pos;
              end else begin
                wr.en      = 1'b1;
                wr.pos     = count_ext;
                wr.key     = req_q.key;
                wr.payload = req_q.payload;
                count_d    = count_q + CW'(1);
              end
            end
            ukt_pkg::FuncRemove: begin
              if (count_q == '0) begin
                status = ukt_pkg::StEmpty;
                idx    = '0;
              end else if (tok[DEPTH].found) begin
                wr.en      = 1'b1;
                wr.pos     = tok[DEPTH].pos;
                wr.key     = tok[DEPTH].last_key;
                wr.payload = tok[DEPTH].last_payload;
                count_d    = count_q - CW'(1);
                idx        = tok[DEPTH].pos;
              end else begin
                status = ukt_pkg::StNotFound;
              end
            end
            default: begin
              if (tok[DEPTH].found) begin
                idx = tok[DEPTH].pos;
              end else begin
                status = ukt_pkg::StNotFound;
              end
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign new_count_ext = ukt_pkg::PosW'(count_d);

  always_comb begin
    done_d       = finish;
    res_d.status = status;
    res_d.index  = idx[ukt_pkg::ResW-1:0];
    res_d.count  = new_count_ext[ukt_pkg::ResW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      capacity_q <= ukt_pkg::CapW'(64);
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (finish) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StScan))
    else $error("Result strobe without a finished scan.");

  a_token_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[DEPTH].valid |-> (state_q == StScan))
    else $error("Scan token left the chain outside a scan.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_ext <= DepthP)
    else $error("Entry count exceeds the table depth.");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !done_o))
    else $error("Request transfer did not start a scan.");

endmodule
